### hw/rtl/eight_bit_alu_register_file_defines.svh
// Assertion macros shared by the eight-bit ALU register file design.
`ifndef EIGHT_BIT_ALU_REGISTER_FILE_DEFINES_SVH
`define EIGHT_BIT_ALU_REGISTER_FILE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define ALURF_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ALURF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ALURF_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define ALURF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

### hw/rtl/alurf_pkg.sv
// Types and constants of the eight-bit ALU register file.
package alurf_pkg;

   localparam int DATA_W = 8;
   localparam int REG_IDX_W = 5;
   localparam int MODE_W = 5;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] CSR_CARRY_IN_ADDR = 2'd0;

   localparam logic [REG_IDX_W-1:0] REG_LOW = 5'd0;
   localparam logic [REG_IDX_W-1:0] REG_HIGH = 5'd1;
   localparam logic [DATA_W-1:0] BYTE_ONES = 8'hff;

   typedef enum logic [MODE_W-1:0] {
      OP_ADD  = 5'd0,
      OP_ADC  = 5'd1,
      OP_SUB  = 5'd2,
      OP_SUBI = 5'd3,
      OP_SBC  = 5'd4,
      OP_SBCI = 5'd5,
      OP_AND  = 5'd6,
      OP_ANDI = 5'd7,
      OP_OR   = 5'd8,
      OP_ORI  = 5'd9,
      OP_EOR  = 5'd10,
      OP_COM  = 5'd11,
      OP_NEG  = 5'd12,
      OP_SBR  = 5'd13,
      OP_CBR  = 5'd14,
      OP_INC  = 5'd15,
      OP_DEC  = 5'd16,
      OP_TST  = 5'd17,
      OP_CLR  = 5'd18,
      OP_SER  = 5'd19,
      OP_MUL  = 5'd20,
      OP_MULS = 5'd21
   } alurf_op_type;

   typedef struct packed {
      logic                 en;
      logic [REG_IDX_W-1:0] rd_addr;
      logic [REG_IDX_W-1:0] rr_addr;
   } alurf_rd_type;

   typedef struct packed {
      logic                 en;
      logic [REG_IDX_W-1:0] addr;
      logic [DATA_W-1:0]    data;
   } alurf_wr_type;

   typedef struct packed {
      logic [REG_IDX_W-1:0] write_index;
      logic [DATA_W-1:0]    write_value;
      logic [DATA_W-1:0]    high_value;
      logic                 is_product;
      logic                 unsupported;
   } alurf_result_type;

endpackage

### hw/rtl/alurf_if.sv
// Handshake channel interfaces for instruction and result beats.
interface alurf_req_if;
   import alurf_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [MODE_W-1:0]    mode;
   logic [REG_IDX_W-1:0] dest_reg;
   logic [REG_IDX_W-1:0] src_reg;
   logic [DATA_W-1:0]    immediate;
   modport source (output valid, mode, dest_reg, src_reg, immediate, input ready);
   modport sink (input valid, mode, dest_reg, src_reg, immediate, output ready);
endinterface

interface alurf_rsp_if;
   import alurf_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [REG_IDX_W-1:0] write_index;
   logic [DATA_W-1:0]    write_value;
   logic [DATA_W-1:0]    high_value;
   logic                 is_product;
   logic                 unsupported;
   modport source (output valid, write_index, write_value, high_value, is_product,
                   unsupported, input ready);
   modport sink (input valid, write_index, write_value, high_value, is_product,
                 unsupported, output ready);
endinterface

### hw/rtl/eight_bit_alu_register_file.sv
// A result beat is registered in execute from the registered operands of its accepted instruction beat.
// The input is ready only in idle: each instruction passes execute after the registered register file
// read, and MUL and MULS also a high byte state, since the single write port writes a product twice.
// A result beat waiting on the sink holds the next instruction in execute and stalls the input.
// Reset clears the register file valid bits (all registers read zero) and carry_in.
`include "eight_bit_alu_register_file_defines.svh"

module eight_bit_alu_register_file #(
   parameter int NUM_REGS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   alurf_req_if.sink                        req_bus,
   alurf_rsp_if.source                      rsp_bus,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [alurf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [alurf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [alurf_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                             csr_pready
);
   import alurf_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_EXEC, S_HIGH} state_type;

   state_type            state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 carry_ff, carry_in;
   logic [MODE_W-1:0]    mode_ff;
   logic [REG_IDX_W-1:0] dest_ff;
   logic [DATA_W-1:0]    imm_ff;
   alurf_result_type     rsp_ff;
   logic                 accept;
   logic                 load_rsp;
   logic                 csr_write;
   logic                 csr_hit;
   alurf_rd_type         rd_req;
   alurf_wr_type         wr_req;
   logic [DATA_W-1:0]    rd_val;
   logic [DATA_W-1:0]    rr_val;
   alurf_result_type     alu_res;

   alurf_regfile #(.NUM_REGS(NUM_REGS)) u_regfile (
      .clock   (clock),
      .reset   (reset),
      .rd_req  (rd_req),
      .wr_req  (wr_req),
      .rd_data (rd_val),
      .rr_data (rr_val)
   );

   alurf_alu u_alu (
      .mode     (mode_ff),
      .dest_reg (dest_ff),
      .rd_val   (rd_val),
      .rr_val   (rr_val),
      .imm      (imm_ff),
      .carry    (carry_ff),
      .res      (alu_res)
   );

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept = req_bus.valid && req_bus.ready;
   assign csr_hit = (csr_paddr == CSR_CARRY_IN_ADDR);
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit;
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? {{(CSR_DATA_W-1){1'b0}}, carry_ff} : '0;

   assign rd_req.en = accept;
   assign rd_req.rd_addr = req_bus.dest_reg;
   assign rd_req.rr_addr = req_bus.src_reg;

   always_comb begin
      state_in = state_ff;
      load_rsp = 1'b0;
      wr_req = '0;
      carry_in = csr_write ? csr_pwdata[0] : carry_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               load_rsp = 1'b1;
               wr_req.en = !alu_res.unsupported;
               wr_req.addr = alu_res.write_index;
               wr_req.data = alu_res.write_value;
               state_in = alu_res.is_product ? S_HIGH : S_IDLE;
            end
         end
         S_HIGH: begin
            wr_req.en = 1'b1;
            wr_req.addr = REG_HIGH;
            wr_req.data = rsp_ff.high_value;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         carry_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         carry_ff <= carry_in;
      end
      if (accept) begin
         mode_ff <= req_bus.mode;
         dest_ff <= req_bus.dest_reg;
         imm_ff <= req_bus.immediate;
      end
      if (load_rsp) begin
         rsp_ff <= alu_res;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.write_index = rsp_ff.write_index;
   assign rsp_bus.write_value = rsp_ff.write_value;
   assign rsp_bus.high_value = rsp_ff.high_value;
   assign rsp_bus.is_product = rsp_ff.is_product;
   assign rsp_bus.unsupported = rsp_ff.unsupported;

   `ALURF_ASSERT_NEXT(a_accept_exec, clock, reset, accept, state_ff == S_EXEC, "accepted beat did not enter execute")
   `ALURF_ASSERT_SAME(a_write_busy, clock, reset, wr_req.en, state_ff != S_IDLE, "register file written while idle")
   `ALURF_ASSERT_NEXT(a_product_high, clock, reset, load_rsp && alu_res.is_product, state_ff == S_HIGH && rsp_valid_ff, "product high byte write missing")
   `ALURF_ASSERT_SAME(a_unsupported_clean, clock, reset, rsp_valid_ff && rsp_ff.unsupported, rsp_ff.write_value == '0 && rsp_ff.high_value == '0 && !rsp_ff.is_product, "unsupported beat carries data")

endmodule

### hw/rtl/alurf_regfile.sv
// Register file memory with two registered read ports, one write port and valid bits.
module alurf_regfile #(
   parameter int NUM_REGS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  alurf_pkg::alurf_rd_type        rd_req,
   input  alurf_pkg::alurf_wr_type        wr_req,
   output logic [alurf_pkg::DATA_W-1:0]   rd_data,
   output logic [alurf_pkg::DATA_W-1:0]   rr_data
);
   import alurf_pkg::*;

   localparam int AW = $clog2(NUM_REGS);

   logic [DATA_W-1:0]   mem [NUM_REGS];
   logic [NUM_REGS-1:0] valid_ff;
   logic [DATA_W-1:0]   rd_data_ff;
   logic [DATA_W-1:0]   rr_data_ff;
   logic                rd_hit;
   logic                rr_hit;
   logic                wr_hit;

   assign rd_hit = (int'(rd_req.rd_addr) < NUM_REGS) && valid_ff[rd_req.rd_addr[AW-1:0]];
   assign rr_hit = (int'(rd_req.rr_addr) < NUM_REGS) && valid_ff[rd_req.rr_addr[AW-1:0]];
   assign wr_hit = wr_req.en && (int'(wr_req.addr) < NUM_REGS);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_hit) begin
         valid_ff[wr_req.addr[AW-1:0]] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_hit) begin
         mem[wr_req.addr[AW-1:0]] <= wr_req.data;
      end
      if (rd_req.en) begin
         rd_data_ff <= rd_hit ? mem[rd_req.rd_addr[AW-1:0]] : '0;
         rr_data_ff <= rr_hit ? mem[rd_req.rr_addr[AW-1:0]] : '0;
      end
   end

   assign rd_data = rd_data_ff;
   assign rr_data = rr_data_ff;

endmodule

### hw/rtl/alurf_alu.sv
// Eight-bit arithmetic, logic and multiply unit that forms one result beat.
module alurf_alu (
   input  logic [alurf_pkg::MODE_W-1:0]    mode,
   input  logic [alurf_pkg::REG_IDX_W-1:0] dest_reg,
   input  logic [alurf_pkg::DATA_W-1:0]    rd_val,
   input  logic [alurf_pkg::DATA_W-1:0]    rr_val,
   input  logic [alurf_pkg::DATA_W-1:0]    imm,
   input  logic                            carry,
   output alurf_pkg::alurf_result_type     res
);
   import alurf_pkg::*;

   logic [DATA_W-1:0]   cval;
   logic                sgn;
   logic [2*DATA_W-1:0] mul_a;
   logic [2*DATA_W-1:0] mul_b;
   logic [2*DATA_W-1:0] prod;

   assign cval = {{(DATA_W-1){1'b0}}, carry};
   assign sgn = (mode == OP_MULS);
   assign mul_a = {{DATA_W{sgn & rd_val[DATA_W-1]}}, rd_val};
   assign mul_b = {{DATA_W{sgn & rr_val[DATA_W-1]}}, rr_val};
   assign prod = mul_a * mul_b;

   always_comb begin
      res = '0;
      res.write_index = dest_reg;
      case (mode) inside
         OP_ADD:  res.write_value = rd_val + rr_val;
         OP_ADC:  res.write_value = rd_val + rr_val + cval;
         OP_SUB:  res.write_value = rd_val - rr_val;
         OP_SUBI: res.write_value = rd_val - imm;
         OP_SBC:  res.write_value = rd_val - rr_val - cval;
         OP_SBCI: res.write_value = rd_val - imm - cval;
         OP_AND:  res.write_value = rd_val & rr_val;
         OP_ANDI: res.write_value = rd_val & imm;
         OP_OR:   res.write_value = rd_val | rr_val;
         OP_ORI, OP_SBR: res.write_value = rd_val | imm;
         OP_EOR:  res.write_value = rd_val ^ rr_val;
         OP_COM:  res.write_value = ~rd_val;
         OP_NEG:  res.write_value = {DATA_W{1'b0}} - rd_val;
         OP_CBR:  res.write_value = rd_val & ~imm;
         OP_INC:  res.write_value = rd_val + {{(DATA_W-1){1'b0}}, 1'b1};
         OP_DEC:  res.write_value = rd_val - {{(DATA_W-1){1'b0}}, 1'b1};
         OP_TST:  res.write_value = rd_val;
         OP_CLR:  res.write_value = '0;
         OP_SER:  res.write_value = BYTE_ONES;
         OP_MUL, OP_MULS: begin
            res.write_index = REG_LOW;
            res.write_value = prod[DATA_W-1:0];
            res.high_value = prod[2*DATA_W-1:DATA_W];
            res.is_product = 1'b1;
         end
         default: begin
            res.write_index = '0;
            res.unsupported = 1'b1;
         end
      endcase
   end

endmodule

### verif/eight_bit_alu_register_file_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the eight-bit ALU register file: predicted writes against result beats.
module eight_bit_alu_register_file_tb;
   import alurf_pkg::*;

   localparam int NUM_REGS = 32;
   localparam int STALL_LIMIT = 2000;
   localparam int MAX_PRINTS = 200;
   localparam logic [MODE_W-1:0] MODE_FIRST_UNUSED = 5'd22;
   localparam logic [MODE_W-1:0] MODE_LAST = 5'd31;

   logic clock = 1'b0;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   alurf_req_if req_bus ();
   alurf_rsp_if rsp_bus ();

   eight_bit_alu_register_file #(.NUM_REGS(NUM_REGS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   logic [DATA_W-1:0] regs_model [NUM_REGS];
   bit carry_model = 1'b0;
   alurf_result_type writes_due [$];
   int n_issued = 0;
   int n_retired = 0;
   int n_products = 0;
   int n_unsupported = 0;
   int n_errors = 0;
   int send_idle_pct;
   int recv_idle_pct;
   int recv_hold = 0;
   int stalled_cycles = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic alurf_result_type retire_instr(input logic [MODE_W-1:0] mode,
                                                     input logic [REG_IDX_W-1:0] rd_idx,
                                                     input logic [REG_IDX_W-1:0] rr_idx,
                                                     input logic [DATA_W-1:0] k);
      logic [DATA_W-1:0] rd;
      logic [DATA_W-1:0] rr;
      logic [DATA_W-1:0] res;
      logic [2*DATA_W-1:0] prod;
      alurf_result_type wr;
      rd = regs_model[rd_idx];
      rr = regs_model[rr_idx];
      wr = '0;
      wr.write_index = rd_idx;
      res = '0;
      case (mode)
         OP_ADD:  res = rd + rr;
         OP_ADC:  res = rd + rr + carry_model;
         OP_SUB:  res = rd - rr;
         OP_SUBI: res = rd - k;
         OP_SBC:  res = rd - rr - carry_model;
         OP_SBCI: res = rd - k - carry_model;
         OP_AND:  res = rd & rr;
         OP_ANDI: res = rd & k;
         OP_OR:   res = rd | rr;
         OP_ORI:  res = rd | k;
         OP_EOR:  res = rd ^ rr;
         OP_COM:  res = ~rd;
         OP_NEG:  res = 8'd0 - rd;
         OP_SBR:  res = rd | k;
         OP_CBR:  res = rd & ~k;
         OP_INC:  res = rd + 8'd1;
         OP_DEC:  res = rd - 8'd1;
         OP_TST:  res = rd;
         OP_CLR:  res = '0;
         OP_SER:  res = BYTE_ONES;
         OP_MUL, OP_MULS: begin
            if (mode == OP_MUL) begin
               prod = {{DATA_W{1'b0}}, rd} * {{DATA_W{1'b0}}, rr};
            end else begin
               prod = {{DATA_W{rd[DATA_W-1]}}, rd} * {{DATA_W{rr[DATA_W-1]}}, rr};
            end
            regs_model[REG_LOW] = prod[DATA_W-1:0];
            regs_model[REG_HIGH] = prod[2*DATA_W-1:DATA_W];
            wr.write_index = REG_LOW;
            wr.write_value = prod[DATA_W-1:0];
            wr.high_value = prod[2*DATA_W-1:DATA_W];
            wr.is_product = 1'b1;
            return wr;
         end
         default: begin
            wr.write_index = '0;
            wr.unsupported = 1'b1;
            return wr;
         end
      endcase
      regs_model[rd_idx] = res;
      wr.write_value = res;
      return wr;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      if (n_errors < MAX_PRINTS) begin
         $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      end
      n_errors++;
   endtask

   always @(posedge clock) begin : track_beats
      alurf_result_type got;
      alurf_result_type want;
      if (reset) begin
         foreach (regs_model[i]) regs_model[i] = '0;
         writes_due.delete();
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            writes_due.push_back(retire_instr(req_bus.mode, req_bus.dest_reg,
                                              req_bus.src_reg, req_bus.immediate));
            n_issued++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.write_index = rsp_bus.write_index;
            got.write_value = rsp_bus.write_value;
            got.high_value = rsp_bus.high_value;
            got.is_product = rsp_bus.is_product;
            got.unsupported = rsp_bus.unsupported;
            n_retired++;
            if (writes_due.size() == 0) begin
               report_mismatch("result beat with nothing outstanding", int'(got), 0);
            end else begin
               want = writes_due.pop_front();
               if (want.is_product) n_products++;
               if (want.unsupported) n_unsupported++;
               if (got.write_index !== want.write_index)
                  report_mismatch("write_index", int'(got.write_index),
                                  int'(want.write_index));
               if (got.write_value !== want.write_value)
                  report_mismatch("write_value", int'(got.write_value),
                                  int'(want.write_value));
               if (got.high_value !== want.high_value)
                  report_mismatch("high_value", int'(got.high_value), int'(want.high_value));
               if (got.is_product !== want.is_product)
                  report_mismatch("is_product", int'(got.is_product), int'(want.is_product));
               if (got.unsupported !== want.unsupported)
                  report_mismatch("unsupported", int'(got.unsupported),
                                  int'(want.unsupported));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (recv_hold > 0) begin
         recv_hold--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || csr_psel) begin
         stalled_cycles = 0;
      end else begin
         stalled_cycles++;
         if (stalled_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
            $display("eight_bit_alu_register_file_tb: done, errors");
            $finish;
         end
      end
   end

   task automatic send_instr(input logic [MODE_W-1:0] mode, input logic [REG_IDX_W-1:0] rd_idx,
                             input logic [REG_IDX_W-1:0] rr_idx, input logic [DATA_W-1:0] k);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.mode <= mode;
      req_bus.dest_reg <= rd_idx;
      req_bus.src_reg <= rr_idx;
      req_bus.immediate <= k;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic drain_writes();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (writes_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_carry(input bit c);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_CARRY_IN_ADDR;
      csr_pwdata <= {{(CSR_DATA_W-1){1'b0}}, c};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      carry_model = c;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[0] !== c) report_mismatch("carry_in readback", int'(csr_prdata[0]), int'(c));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_directed_ops();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_carry(1'b0);
      send_instr(OP_SER, 5'd31, 5'd0, 8'h00);
      send_instr(OP_INC, 5'd2, 5'd0, 8'hff);
      send_instr(OP_ADD, 5'd31, 5'd31, 8'h00);
      send_instr(OP_ADC, 5'd2, 5'd31, 8'h00);
      send_instr(OP_SUB, 5'd0, 5'd31, 8'h00);
      send_instr(OP_SUBI, 5'd3, 5'd0, 8'hff);
      send_instr(OP_SBC, 5'd4, 5'd31, 8'h00);
      send_instr(OP_SBCI, 5'd5, 5'd0, 8'h00);
      send_instr(OP_AND, 5'd31, 5'd2, 8'h00);
      send_instr(OP_ANDI, 5'd3, 5'd0, 8'h0f);
      send_instr(OP_OR, 5'd4, 5'd3, 8'h00);
      send_instr(OP_ORI, 5'd6, 5'd0, 8'hff);
      send_instr(OP_EOR, 5'd6, 5'd6, 8'h00);
      send_instr(OP_COM, 5'd0, 5'd0, 8'h00);
      send_instr(OP_NEG, 5'd31, 5'd0, 8'h00);
      send_instr(OP_SBR, 5'd7, 5'd0, 8'h80);
      send_instr(OP_CBR, 5'd3, 5'd0, 8'hff);
      send_instr(OP_DEC, 5'd8, 5'd0, 8'h00);
      send_instr(OP_TST, 5'd8, 5'd0, 8'h00);
      send_instr(OP_CLR, 5'd8, 5'd31, 8'hff);
      send_instr(OP_MUL, 5'd8, 5'd8, 8'h00);
      send_instr(OP_MUL, 5'd4, 5'd4, 8'h00);
      send_instr(OP_MULS, 5'd4, 5'd7, 8'h00);
      send_instr(MODE_FIRST_UNUSED, 5'd31, 5'd31, 8'hff);
      send_instr(MODE_LAST, 5'd9, 5'd3, 8'h5a);
      drain_writes();
   endtask

   task automatic test_carry_ops();
      write_carry(1'b1);
      send_instr(OP_ADC, 5'd6, 5'd6, 8'h00);
      send_instr(OP_SER, 5'd10, 5'd0, 8'h00);
      send_instr(OP_ADC, 5'd10, 5'd10, 8'h00);
      send_instr(OP_SBC, 5'd11, 5'd11, 8'h00);
      send_instr(OP_SBCI, 5'd12, 5'd0, 8'hff);
      send_instr(OP_SBCI, 5'd10, 5'd0, 8'h00);
      send_instr(OP_MULS, 5'd10, 5'd10, 8'h00);
      drain_writes();
   endtask

   task automatic test_random_mix(input int count, input int send_pct, input int recv_pct,
                                  input bit c);
      logic [MODE_W-1:0] mode;
      logic [REG_IDX_W-1:0] rd_idx;
      logic [REG_IDX_W-1:0] rr_idx;
      logic [DATA_W-1:0] k;
      write_carry(c);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (count) begin
         if ($urandom_range(99) < 8) begin
            mode = MODE_W'($urandom_range(MODE_LAST, MODE_FIRST_UNUSED));
         end else begin
            mode = MODE_W'($urandom_range(OP_MULS, OP_ADD));
         end
         rd_idx = REG_IDX_W'(($urandom_range(1) != 0) ? $urandom_range(3)
                                                        : $urandom_range(NUM_REGS - 1));
         rr_idx = REG_IDX_W'(($urandom_range(1) != 0) ? $urandom_range(3)
                                                        : $urandom_range(NUM_REGS - 1));
         case ($urandom_range(9))
            0: k = '0;
            1: k = BYTE_ONES;
            default: k = DATA_W'($urandom_range(255));
         endcase
         send_instr(mode, rd_idx, rr_idx, k);
      end
      drain_writes();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      recv_hold = 80;
      repeat (40) begin
         send_instr(MODE_W'($urandom_range(OP_MULS, OP_ADD)),
                    REG_IDX_W'($urandom_range(NUM_REGS - 1)),
                    REG_IDX_W'($urandom_range(NUM_REGS - 1)),
                    DATA_W'($urandom_range(255)));
      end
      drain_writes();
   endtask

   initial begin
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.mode <= '0;
      req_bus.dest_reg <= '0;
      req_bus.src_reg <= '0;
      req_bus.immediate <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_ops();
      test_carry_ops();
      test_random_mix(330, 26, 48, 1'b0);
      test_random_mix(330, 48, 26, 1'b1);
      test_random_mix(330, 0, 0, 1'b0);
      test_backpressure();
      repeat (8) @(posedge clock);

      if (writes_due.size() != 0) report_mismatch("results never returned", writes_due.size(), 0);
      $display("Ran %0d instructions and checked %0d result beats, %0d products, %0d unused modes.",
               n_issued, n_retired, n_products, n_unsupported);
      $display("Covered every operation with carry_in at 0 and 1, idle gaps and a long stall.");
      if (n_errors == 0) begin
         $display("eight_bit_alu_register_file_tb: done, clean");
      end else begin
         $display("eight_bit_alu_register_file_tb: done, errors");
      end
      $finish;
   end

endmodule
